// ===== rtl/core/tcpq_pkg.sv =====
// tcpq_pkg: shared types and constants for the two-class priority queue merger
// no dependencies; imported by tcpq_fifo, tcpq_ctrl and the top level
`timescale 1ns / 1ps

package tcpq_pkg;

    // ticket and field widths
    localparam int TICKET_W = 10;
    localparam int LIMIT_W  = 5;
    localparam int MOVED_W  = 5;
    localparam int SCOUNT_W = 5;
    localparam int QCOUNT_W = 7;

    // accepted ticket range
    localparam logic [TICKET_W-1:0] TICKET_MIN = 10'd100;
    localparam logic [TICKET_W-1:0] TICKET_MAX = 10'd999;

    // service limit after reset
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd12;

    // default queue depths
    localparam int DEF_INPUT_DEPTH   = 64;
    localparam int DEF_SERVICE_DEPTH = 16;

    typedef enum logic [1:0] {
        OP_ENQ_NORMAL   = 2'd0,
        OP_ENQ_PRIORITY = 2'd1,
        OP_MERGE        = 2'd2,
        OP_DEQUEUE      = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK         = 2'd0,
        STS_BAD_TICKET = 2'd1,
        STS_FULL       = 2'd2,
        STS_EMPTY      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MERGE,
        ST_FIN
    } t_state;

    // command from the sequencer to one queue
    typedef struct packed {
        logic                push;
        logic                pop;
        logic [TICKET_W-1:0] wdata;
    } t_fifo_cmd;

    // fill flags from one queue
    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_stat;

endpackage

// ===== rtl/core/tcpq_fifo.sv =====
// tcpq_fifo: ring buffer of tickets with head, tail and count, registered read
// depends on tcpq_pkg for the command and flag structs
`timescale 1ns / 1ps

module tcpq_fifo
    import tcpq_pkg::*;
#(
    parameter int DEPTH = DEF_INPUT_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_fifo_cmd                  i_cmd,
    output t_fifo_stat                 o_stat,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic [TICKET_W-1:0]        o_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [TICKET_W-1:0] r_mem [DEPTH];
    logic [TICKET_W-1:0] r_rdata;
    logic [AW-1:0]       r_head, n_head;
    logic [AW-1:0]       r_tail, n_tail;
    logic [CW-1:0]       r_count, n_count;

    // storage write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= i_cmd.wdata;
        end
        if (i_cmd.pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

    // pointer and count update with wrap at the last entry
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_cmd.push) begin
            n_tail = (r_tail == AW'(DEPTH-1)) ? '0 : r_tail + 1'b1;
        end
        if (i_cmd.pop) begin
            n_head = (r_head == AW'(DEPTH-1)) ? '0 : r_head + 1'b1;
        end
        if (i_cmd.push && !i_cmd.pop) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.pop && !i_cmd.push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_count      = r_count;
    assign o_rdata      = r_rdata;

endmodule

// ===== rtl/core/tcpq_ctrl.sv =====
// tcpq_ctrl: sequencer that runs enqueue, merge and dequeue over the three queues
// depends on tcpq_pkg; drives tcpq_fifo commands and holds the result register
`timescale 1ns / 1ps

module tcpq_ctrl
    import tcpq_pkg::*;
#(
    parameter int INPUT_DEPTH   = DEF_INPUT_DEPTH,
    parameter int SERVICE_DEPTH = DEF_SERVICE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request side
    input  logic                               i_req_valid,
    output logic                               o_req_ready,
    input  t_opcode                            i_req_op,
    input  logic [TICKET_W-1:0]                i_req_ticket,
    input  logic [LIMIT_W-1:0]                 i_limit,
    // queue interfaces
    output t_fifo_cmd                          o_nrm_cmd,
    output t_fifo_cmd                          o_pri_cmd,
    output t_fifo_cmd                          o_svc_cmd,
    input  t_fifo_stat                         i_nrm_stat,
    input  t_fifo_stat                         i_pri_stat,
    input  t_fifo_stat                         i_svc_stat,
    input  logic [$clog2(INPUT_DEPTH+1)-1:0]   i_nrm_count,
    input  logic [$clog2(INPUT_DEPTH+1)-1:0]   i_pri_count,
    input  logic [$clog2(SERVICE_DEPTH+1)-1:0] i_svc_count,
    input  logic [TICKET_W-1:0]                i_nrm_rdata,
    input  logic [TICKET_W-1:0]                i_pri_rdata,
    input  logic [TICKET_W-1:0]                i_svc_rdata,
    // result side
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output t_status                            o_res_status,
    output logic [TICKET_W-1:0]                o_res_ticket,
    output logic [MOVED_W-1:0]                 o_res_moved,
    output logic [SCOUNT_W-1:0]                o_res_svc_count,
    output logic [QCOUNT_W-1:0]                o_res_nrm_count,
    output logic [QCOUNT_W-1:0]                o_res_pri_count
);

    localparam int SCW = $clog2(SERVICE_DEPTH+1);

    t_state              r_state, n_state;
    t_opcode             r_op, n_op;
    logic [TICKET_W-1:0] r_ticket, n_ticket;
    t_status             r_status, n_status;
    logic [SCW-1:0]      r_moved, n_moved;
    logic [SCW-1:0]      r_proj, n_proj;
    logic                r_push_v, n_push_v;
    logic                r_push_pri, n_push_pri;

    logic                r_o_valid;
    t_status             r_o_status;
    logic [TICKET_W-1:0] r_o_ticket;
    logic [MOVED_W-1:0]  r_o_moved;
    logic [SCOUNT_W-1:0] r_o_svc;
    logic [QCOUNT_W-1:0] r_o_nrm;
    logic [QCOUNT_W-1:0] r_o_pri;

    logic                w_ticket_ok;
    logic                w_issue;
    logic                w_load;
    logic [31:0]         w_moved32;
    logic [31:0]         w_svc32;
    logic [31:0]         w_nrm32;
    logic [31:0]         w_pri32;

    // one more ticket fits under the limit and the service queue depth and a source holds one
    assign w_issue = (32'(r_proj) < 32'(i_limit)) && (r_proj < SCW'(SERVICE_DEPTH))
                     && (!i_pri_stat.empty || !i_nrm_stat.empty);
    assign w_ticket_ok = (r_ticket >= TICKET_MIN) && (r_ticket <= TICKET_MAX);
    assign w_load = (r_state == ST_FIN) && (!r_o_valid || i_res_ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = (r_op == OP_MERGE) ? ST_MERGE : ST_FIN;
            end
            ST_MERGE: begin
                if (!w_issue && !r_push_v) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // queue commands
    always_comb begin
        o_req_ready = 1'b0;
        o_nrm_cmd   = '0;
        o_pri_cmd   = '0;
        o_svc_cmd   = '0;
        o_nrm_cmd.wdata = r_ticket;
        o_pri_cmd.wdata = r_ticket;
        o_svc_cmd.wdata = r_push_pri ? i_pri_rdata : i_nrm_rdata;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
            end
            ST_EXEC: begin
                case (r_op)
                    OP_ENQ_NORMAL: begin
                        o_nrm_cmd.push = w_ticket_ok && !i_nrm_stat.full;
                    end
                    OP_ENQ_PRIORITY: begin
                        o_pri_cmd.push = w_ticket_ok && !i_pri_stat.full;
                    end
                    OP_DEQUEUE: begin
                        o_svc_cmd.pop = !i_svc_stat.empty;
                    end
                    default: begin
                    end
                endcase
            end
            ST_MERGE: begin
                // priority queue drains first; the pop data is registered and pushed in the cycle after the pop
                o_pri_cmd.pop  = w_issue && !i_pri_stat.empty;
                o_nrm_cmd.pop  = w_issue && i_pri_stat.empty;
                o_svc_cmd.push = r_push_v;
            end
            default: begin
            end
        endcase
    end

    // request and merge bookkeeping
    always_comb begin
        n_op       = r_op;
        n_ticket   = r_ticket;
        n_status   = r_status;
        n_moved    = r_moved;
        n_proj     = r_proj;
        n_push_v   = 1'b0;
        n_push_pri = r_push_pri;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_op     = i_req_op;
                    n_ticket = i_req_ticket;
                    n_status = STS_OK;
                    n_moved  = '0;
                end
            end
            ST_EXEC: begin
                n_proj = i_svc_count;
                case (r_op)
                    OP_ENQ_NORMAL: begin
                        if (!w_ticket_ok) begin
                            n_status = STS_BAD_TICKET;
                        end else if (i_nrm_stat.full) begin
                            n_status = STS_FULL;
                        end
                    end
                    OP_ENQ_PRIORITY: begin
                        if (!w_ticket_ok) begin
                            n_status = STS_BAD_TICKET;
                        end else if (i_pri_stat.full) begin
                            n_status = STS_FULL;
                        end
                    end
                    OP_DEQUEUE: begin
                        if (i_svc_stat.empty) begin
                            n_status = STS_EMPTY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_MERGE: begin
                if (w_issue) begin
                    n_proj     = r_proj + 1'b1;
                    n_moved    = r_moved + 1'b1;
                    n_push_v   = 1'b1;
                    n_push_pri = !i_pri_stat.empty;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_push_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_push_v <= n_push_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_ticket   <= n_ticket;
        r_status   <= n_status;
        r_moved    <= n_moved;
        r_proj     <= n_proj;
        r_push_pri <= n_push_pri;
    end

    // counts masked to the result field widths
    assign w_moved32 = 32'(r_moved);
    assign w_svc32   = 32'(i_svc_count);
    assign w_nrm32   = 32'(i_nrm_count);
    assign w_pri32   = 32'(i_pri_count);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_status <= r_status;
            r_o_ticket <= (r_op == OP_DEQUEUE && r_status == STS_OK) ? i_svc_rdata : '0;
            r_o_moved  <= w_moved32[MOVED_W-1:0];
            r_o_svc    <= w_svc32[SCOUNT_W-1:0];
            r_o_nrm    <= w_nrm32[QCOUNT_W-1:0];
            r_o_pri    <= w_pri32[QCOUNT_W-1:0];
        end
    end

    assign o_res_valid     = r_o_valid;
    assign o_res_status    = r_o_status;
    assign o_res_ticket    = r_o_ticket;
    assign o_res_moved     = r_o_moved;
    assign o_res_svc_count = r_o_svc;
    assign o_res_nrm_count = r_o_nrm;
    assign o_res_pri_count = r_o_pri;

endmodule

// ===== rtl/core/two_class_priority_queue_merger.sv =====
// two_class_priority_queue_merger: top level with the limit register and stream packing
// depends on tcpq_pkg, tcpq_fifo and tcpq_ctrl
//
// channel  | direction | payload
// s_axis   | in        | tuser opcode, tdata ticket
// m_axis   | out       | tuser status, tdata ticket_out and the four counts
// cfg      | in        | service_limit, written when i_cfg_we is high
//
// enqueue and dequeue pass through the EXEC and FIN states from accept to result; a
// merge passes through EXEC, MERGE and FIN, one ticket moved per cycle by the
// pop/push pair between an input queue and the service queue.
// one request is in work at a time; the next is taken while a result waits.
// reset clears all queue pointers and counts and sets the limit to 12.
`timescale 1ns / 1ps

module two_class_priority_queue_merger
    import tcpq_pkg::*;
#(
    parameter int INPUT_DEPTH   = DEF_INPUT_DEPTH,
    parameter int SERVICE_DEPTH = DEF_SERVICE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [15:0]        s_axis_tdata,   // [9:0] ticket, [15:10] zero
    input  logic [1:0]         s_axis_tuser,   // [1:0] opcode
    // result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [39:0]        m_axis_tdata,   // [9:0] ticket_out, [14:10] moved_count,
                                               // [19:15] service_count,
                                               // [26:20] normal_count,
                                               // [33:27] priority_count, [39:34] zero
    output logic [1:0]         m_axis_tuser,   // [1:0] status
    // limit register
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata
);

    localparam int ICW = $clog2(INPUT_DEPTH+1);
    localparam int SCW = $clog2(SERVICE_DEPTH+1);

    logic [LIMIT_W-1:0]  r_limit;

    t_fifo_cmd           w_nrm_cmd, w_pri_cmd, w_svc_cmd;
    t_fifo_stat          w_nrm_stat, w_pri_stat, w_svc_stat;
    logic [ICW-1:0]      w_nrm_count, w_pri_count;
    logic [SCW-1:0]      w_svc_count;
    logic [TICKET_W-1:0] w_nrm_rdata, w_pri_rdata, w_svc_rdata;

    t_status             w_status;
    logic [TICKET_W-1:0] w_ticket_out;
    logic [MOVED_W-1:0]  w_moved;
    logic [SCOUNT_W-1:0] w_svc_out;
    logic [QCOUNT_W-1:0] w_nrm_out;
    logic [QCOUNT_W-1:0] w_pri_out;

    // service limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    tcpq_fifo #(.DEPTH(INPUT_DEPTH)) u_nrm_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_nrm_cmd),
        .o_stat  (w_nrm_stat),
        .o_count (w_nrm_count),
        .o_rdata (w_nrm_rdata)
    );

    tcpq_fifo #(.DEPTH(INPUT_DEPTH)) u_pri_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_pri_cmd),
        .o_stat  (w_pri_stat),
        .o_count (w_pri_count),
        .o_rdata (w_pri_rdata)
    );

    tcpq_fifo #(.DEPTH(SERVICE_DEPTH)) u_svc_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_svc_cmd),
        .o_stat  (w_svc_stat),
        .o_count (w_svc_count),
        .o_rdata (w_svc_rdata)
    );

    tcpq_ctrl #(
        .INPUT_DEPTH   (INPUT_DEPTH),
        .SERVICE_DEPTH (SERVICE_DEPTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (s_axis_tvalid),
        .o_req_ready     (s_axis_tready),
        .i_req_op        (t_opcode'(s_axis_tuser)),
        .i_req_ticket    (s_axis_tdata[TICKET_W-1:0]),
        .i_limit         (r_limit),
        .o_nrm_cmd       (w_nrm_cmd),
        .o_pri_cmd       (w_pri_cmd),
        .o_svc_cmd       (w_svc_cmd),
        .i_nrm_stat      (w_nrm_stat),
        .i_pri_stat      (w_pri_stat),
        .i_svc_stat      (w_svc_stat),
        .i_nrm_count     (w_nrm_count),
        .i_pri_count     (w_pri_count),
        .i_svc_count     (w_svc_count),
        .i_nrm_rdata     (w_nrm_rdata),
        .i_pri_rdata     (w_pri_rdata),
        .i_svc_rdata     (w_svc_rdata),
        .o_res_valid     (m_axis_tvalid),
        .i_res_ready     (m_axis_tready),
        .o_res_status    (w_status),
        .o_res_ticket    (w_ticket_out),
        .o_res_moved     (w_moved),
        .o_res_svc_count (w_svc_out),
        .o_res_nrm_count (w_nrm_out),
        .o_res_pri_count (w_pri_out)
    );

    // result packing
    assign m_axis_tuser = w_status;
    assign m_axis_tdata = {6'd0, w_pri_out, w_nrm_out, w_svc_out, w_moved, w_ticket_out};

endmodule
